FILE: hw/rtl/hybrid_quicksort_insertion_defines.svh
// Assertion macros for the hybrid sorter.
// Depends on nothing; included by the top level.
`ifndef HYBRID_QUICKSORT_INSERTION_DEFINES_SVH
`define HYBRID_QUICKSORT_INSERTION_DEFINES_SVH
// Clocked implication checked outside reset.
`define HQI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also evaluated during reset.
`define HQI_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hw/rtl/hqi_pkg.sv
// Shared types and constants for the hybrid sorter.
// Depends on nothing.
package hqi_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned StoreDepth = 64;
	localparam int unsigned IdxW = 6;
	localparam int unsigned StackDepth = 8;
	localparam int unsigned SpW = 4;
	typedef logic signed [DataW-1:0] data_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef struct packed {
		idx_t lo;
		idx_t hi;
	} range_t;
endpackage

FILE: hw/rtl/hybrid_quicksort_insertion.sv
// Hybrid sorter: element store, quicksort/insertion sequencer and output drain.
// Depends on hqi_pkg and hybrid_quicksort_insertion_defines.svh.
//
// Elements load at one transaction per cycle while in_stall is low. The
// transaction marked last starts the sort, and in_stall stays high until the
// whole run has drained. The sort reuses a single read port, one write port
// and one signed comparator. An insertion step reads two elements, compares
// them and writes them back when it swaps. A partition step reads one element
// with the pivot held, compares it and swaps it with element i when it is not
// above the pivot. Each partition first fetches the pivot and ends with the
// final pivot swap, and each popped range is loaded from the stack. The drain
// presents one element at a time and waits while out_stall is high. Already
// ordered input or many equal values push the partition toward N*N/2 compares.
// Ranges of SMALL_RANGE_CUTOFF or fewer are finished by insertion sort.
`include "hybrid_quicksort_insertion_defines.svh"
module hybrid_quicksort_insertion #(
	parameter int unsigned MAX_ELEMENTS = 64,
	parameter int unsigned SMALL_RANGE_CUTOFF = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  hqi_pkg::data_t in_value,
	input  logic in_last,
	output logic out_valid,
	input  logic out_stall,
	output hqi_pkg::data_t out_value,
	output logic out_last,
	output logic out_overflow
);
	import hqi_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_RANGE,
		S_INS_RD_J, S_INS_RD_JM, S_INS_CMP, S_INS_WR2,
		S_PIV_RD, S_PIV_WAIT, S_LP_RD, S_LP_CMP, S_LP_WR2,
		S_FIN_RDI, S_FIN_WAIT, S_FIN_WR2, S_POP, S_POP_WAIT,
		S_OUT_RD, S_OUT_WAIT, S_OUT
	} state_t;

	// Step of the partition swap sequence.
	typedef enum logic [1:0] {
		PH_SWAP, PH_PIVOT, PH_DONE
	} phase_t;

	state_t state_q;
	data_t mem [StoreDepth];
	range_t stack_mem [StackDepth];
	logic [IdxW:0] count_q;
	logic ovf_q;
	logic [SpW-1:0] sp_q;
	logic signed [IdxW+1:0] lo_q, hi_q, i_q, j_q;
	phase_t p_q;
	data_t pivot_q, a_q, b_q, rd_q;
	idx_t wa_q;
	data_t wd_q;
	range_t pop_q;
	logic [IdxW:0] k_q;
	logic pend_q;

	// Single read port with a registered output; loads and swaps share the write port.
	idx_t ra;
	logic we;
	logic load_we;
	assign load_we = (state_q == S_LOAD) && in_valid && (count_q < (IdxW+1)'(MAX_ELEMENTS));
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[count_q[IdxW-1:0]] <= in_value;
		end else if (we) begin
			mem[wa_q] <= wd_q;
		end
		rd_q <= mem[ra];
	end

	logic signed [IdxW+1:0] size_w, lsz, rsz;
	assign size_w = hi_q - lo_q + 8'sd1;
	assign lsz = i_q - lo_q;
	assign rsz = hi_q - i_q;

	// The one comparator takes the pivot during partition, else the held element.
	data_t cmp_op;
	logic cmp_lt;
	assign cmp_op = (state_q == S_LP_CMP) ? pivot_q : a_q;
	assign cmp_lt = cmp_op < rd_q;

	// Read address and write strobe come from the sequencer state. The second
	// half of a swap is written in the cycle after the swap state.
	always_comb begin
		ra = '0;
		we = pend_q;
		unique case (state_q)
			S_INS_RD_J, S_LP_RD: ra = j_q[IdxW-1:0];
			S_INS_RD_JM: ra = idx_t'(j_q - 8'sd1);
			S_PIV_RD: ra = hi_q[IdxW-1:0];
			S_FIN_RDI: ra = i_q[IdxW-1:0];
			S_OUT_RD: ra = k_q[IdxW-1:0];
			S_OUT: ra = idx_t'(k_q + 7'd1);
			S_INS_WR2, S_LP_WR2, S_FIN_WR2: we = 1'b1;
			default: ra = '0;
		endcase
	end

	logic out_fire;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = (state_q != S_LOAD);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			sp_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= (state_q == S_INS_WR2) || (state_q == S_FIN_WR2);
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (count_q < (IdxW+1)'(MAX_ELEMENTS)) begin
							count_q <= count_q + 7'd1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							lo_q <= '0;
							if (count_q < (IdxW+1)'(MAX_ELEMENTS)) begin
								hi_q <= $signed({1'b0, count_q});
							end else begin
								hi_q <= $signed({1'b0, count_q}) - 8'sd1;
							end
							sp_q <= '0;
							state_q <= S_RANGE;
						end
					end
				end
				S_RANGE: begin
					if (size_w <= $signed(8'(SMALL_RANGE_CUTOFF))) begin
						i_q <= lo_q + 8'sd1;
						j_q <= lo_q + 8'sd1;
						state_q <= (lo_q + 8'sd1 <= hi_q) ? S_INS_RD_J : S_POP;
					end else begin
						i_q <= lo_q;
						j_q <= lo_q;
						state_q <= S_PIV_RD;
					end
				end
				// Insertion sort: compare element j with j-1, swap and walk down.
				S_INS_RD_J: state_q <= S_INS_RD_JM;
				S_INS_RD_JM: begin
					a_q <= rd_q;
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (cmp_lt) begin
						wa_q <= idx_t'(j_q - 8'sd1);
						wd_q <= a_q;
						b_q <= rd_q;
						state_q <= S_INS_WR2;
					end else if (i_q + 8'sd1 <= hi_q) begin
						i_q <= i_q + 8'sd1;
						j_q <= i_q + 8'sd1;
						state_q <= S_INS_RD_J;
					end else begin
						state_q <= S_POP;
					end
				end
				S_INS_WR2: begin
					wa_q <= j_q[IdxW-1:0];
					wd_q <= b_q;
					if (j_q - 8'sd1 >= lo_q + 8'sd1) begin
						j_q <= j_q - 8'sd1;
						state_q <= S_INS_RD_J;
					end else if (i_q + 8'sd1 <= hi_q) begin
						i_q <= i_q + 8'sd1;
						j_q <= i_q + 8'sd1;
						state_q <= S_INS_RD_J;
					end else begin
						state_q <= S_POP;
					end
				end
				// Lomuto partition around the last element.
				S_PIV_RD: state_q <= S_PIV_WAIT;
				S_PIV_WAIT: begin
					pivot_q <= rd_q;
					state_q <= S_LP_RD;
				end
				S_LP_RD: state_q <= S_LP_CMP;
				S_LP_CMP: begin
					if (!cmp_lt) begin
						a_q <= rd_q;
						state_q <= S_FIN_RDI;
						p_q <= PH_SWAP;
					end else if (j_q + 8'sd1 < hi_q) begin
						j_q <= j_q + 8'sd1;
						state_q <= S_LP_RD;
					end else begin
						p_q <= PH_PIVOT;
						j_q <= hi_q;
						a_q <= pivot_q;
						state_q <= S_FIN_RDI;
					end
				end
				// Swap element i with the held one at j (or with the pivot at hi).
				S_FIN_RDI: state_q <= S_FIN_WAIT;
				S_FIN_WAIT: begin
					wa_q <= j_q[IdxW-1:0];
					wd_q <= rd_q;
					state_q <= S_FIN_WR2;
				end
				S_FIN_WR2: begin
					wa_q <= i_q[IdxW-1:0];
					wd_q <= a_q;
					if (p_q == PH_SWAP) begin
						i_q <= i_q + 8'sd1;
						if (j_q + 8'sd1 < hi_q) begin
							j_q <= j_q + 8'sd1;
							state_q <= S_LP_RD;
						end else begin
							p_q <= PH_PIVOT;
							j_q <= hi_q;
							a_q <= pivot_q;
							state_q <= S_LP_WR2;
						end
					end else begin
						state_q <= S_LP_WR2;
					end
				end
				// Final pivot swap is a read of i after i advanced; split the ranges.
				S_LP_WR2: begin
					if (p_q == PH_PIVOT && j_q == hi_q && wa_q != i_q[IdxW-1:0]) begin
						p_q <= PH_DONE;
						state_q <= S_FIN_RDI;
					end else begin
						if (lsz - 8'sd1 <= rsz - 8'sd1) begin
							if (rsz >= 8'sd2 && sp_q < SpW'(StackDepth)) begin
								stack_mem[sp_q[SpW-2:0]] <= '{lo: idx_t'(i_q + 8'sd1),
									hi: hi_q[IdxW-1:0]};
								sp_q <= sp_q + 4'd1;
							end
							hi_q <= i_q - 8'sd1;
						end else begin
							if (lsz >= 8'sd2 && sp_q < SpW'(StackDepth)) begin
								stack_mem[sp_q[SpW-2:0]] <= '{lo: lo_q[IdxW-1:0],
									hi: idx_t'(i_q - 8'sd1)};
								sp_q <= sp_q + 4'd1;
							end
							lo_q <= i_q + 8'sd1;
						end
						state_q <= S_RANGE;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						k_q <= '0;
						state_q <= (count_q == '0) ? S_LOAD : S_OUT_RD;
						if (count_q == '0) ovf_q <= 1'b0;
					end else begin
						pop_q <= stack_mem[sp_q[SpW-2:0] - 3'd1];
						sp_q <= sp_q - 4'd1;
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					lo_q <= $signed({2'b00, pop_q.lo});
					hi_q <= $signed({2'b00, pop_q.hi});
					state_q <= S_RANGE;
				end
				// Drain the sorted store.
				S_OUT_RD: state_q <= S_OUT_WAIT;
				S_OUT_WAIT: begin
					out_value <= rd_q;
					out_last <= (k_q + 7'd1 == count_q);
					out_overflow <= ovf_q;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_fire) begin
						if (out_last) begin
							out_valid <= 1'b0;
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q <= k_q + 7'd1;
							state_q <= S_OUT_RD;
							out_valid <= 1'b0;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`HQI_ASSERT(a_out_only_drain, clk, arst_n, out_valid |-> (state_q == S_OUT), "output outside drain")
	`HQI_ASSERT(a_stack_bound, clk, arst_n, sp_q <= SpW'(StackDepth), "range stack overrun")
	`HQI_ASSERT(a_count_bound, clk, arst_n, count_q <= (IdxW+1)'(MAX_ELEMENTS), "count above capacity")
endmodule
